[sv/gpm_pkg.sv]
// ----------------------------------------------------------------------------
// gpm_pkg
// Types and constants shared by the gamepad poll monitor.
// ----------------------------------------------------------------------------
package gpm_pkg;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 16;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] REG_IDLE_DIM_FRAMES = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_IDLE_OFF_FRAMES = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_DIM_LEVEL       = 2'd2;

  localparam logic [15:0] IDLE_DIM_FRAMES_RESET = 16'd600;
  localparam logic [15:0] IDLE_OFF_FRAMES_RESET = 16'd1800;
  localparam logic [7:0]  DIM_LEVEL_RESET       = 8'd70;

  // event commands
  localparam logic [1:0] CMD_LATCH_FALL = 2'd0;
  localparam logic [1:0] CMD_CLOCK_FALL = 2'd1;
  localparam logic [1:0] CMD_CLOCK_RISE = 2'd2;
  localparam logic [1:0] CMD_POLL       = 2'd3;

  // backlight states
  localparam logic [1:0] LIGHT_FULL = 2'd0;
  localparam logic [1:0] LIGHT_DIM  = 2'd1;
  localparam logic [1:0] LIGHT_OFF  = 2'd2;

  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam logic [7:0] LEVEL_OFF  = 8'd0;

  localparam logic [4:0] FRAME_BITS_WIDE   = 5'd16;
  localparam logic [4:0] FRAME_BITS_NARROW = 5'd8;
  localparam logic [4:0] CAPTURE_BITS      = 5'd16;

  localparam logic [11:0] MASK_WIDE   = 12'hFFF;
  localparam logic [11:0] MASK_NARROW = 12'h0FF;
  localparam logic [11:0] COMBO_ONE   = 12'h005;
  localparam logic [11:0] COMBO_TWO   = 12'hF05;

  typedef struct packed {
    logic [1:0] command;
    logic       data_line;
    logic       clock_line_pulled;
  } in_item_t;

  typedef struct packed {
    logic [11:0] button_bits;
    logic        frame_done;
    logic [15:0] idle_frames;
    logic [7:0]  backlight_level;
    logic        display_on;
    logic        wide_model;
    logic        pal_region;
    logic        poll_taken;
    logic        model_changed;
    logic        clocking_res;
  } out_item_t;

endpackage

[sv/gamepad_poll_monitor_unit.sv]
// ----------------------------------------------------------------------------
// gamepad_poll_monitor_unit
// Follows serial gamepad poll events and drives backlight and model status.
// ----------------------------------------------------------------------------
// Each event transaction (latch fall, clock fall, clock rise, poll) is handled
// in the cycle it is accepted and gives exactly one result transaction. One
// event per cycle is sustained: the state update is a single pass of short
// logic into the state registers and the output register, and a one-entry
// skid register behind the output keeps input acceptance going for one more
// event while a result waits; in_stall rises only when the skid is full.
// Configuration writes are always ready and take effect on the next event.
module gamepad_poll_monitor_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gpm_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gpm_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpm_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [gpm_pkg::CfgDataWidth-1:0]    cfg_data
);

  // configuration
  logic [15:0] idle_dim_frames;
  logic [15:0] idle_off_frames;
  logic [7:0]  dim_level;

  // monitor state
  logic [15:0] capture_word, capture_word_next;
  logic [4:0]  bit_index, bit_index_next;
  logic        running, running_next;
  logic [15:0] idle_counter, idle_counter_next;
  logic [1:0]  light_state, light_state_next;
  logic        model_wide, model_wide_next;
  logic [11:0] previous_buttons, previous_buttons_next;
  logic [11:0] shown_buttons, shown_buttons_next;
  logic        region_flag, region_flag_next;

  // output side
  logic               skid_valid;
  gpm_pkg::out_item_t skid_data;
  gpm_pkg::out_item_t result;

  logic        accept;
  logic        pop;
  logic [11:0] valid_mask;
  logic [11:0] held;
  logic [4:0]  index_inc;
  logic [4:0]  frame_limit;
  logic        frame_done;
  logic        poll_taken;
  logic        model_changed;
  logic        saved_combo;
  logic        previous_combo;
  logic [7:0]  level;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_dim_frames <= gpm_pkg::IDLE_DIM_FRAMES_RESET;
      idle_off_frames <= gpm_pkg::IDLE_OFF_FRAMES_RESET;
      dim_level       <= gpm_pkg::DIM_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gpm_pkg::REG_IDLE_DIM_FRAMES: idle_dim_frames <= cfg_data;
        gpm_pkg::REG_IDLE_OFF_FRAMES: idle_off_frames <= cfg_data;
        gpm_pkg::REG_DIM_LEVEL:       dim_level       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign valid_mask     = model_wide ? gpm_pkg::MASK_WIDE : gpm_pkg::MASK_NARROW;
  assign held           = capture_word[11:0] & valid_mask;
  assign index_inc      = bit_index + 5'd1;
  assign frame_limit    = model_wide ? gpm_pkg::FRAME_BITS_WIDE : gpm_pkg::FRAME_BITS_NARROW;
  assign saved_combo    = (held == gpm_pkg::COMBO_ONE) || (held == gpm_pkg::COMBO_TWO);
  assign previous_combo = (previous_buttons == gpm_pkg::COMBO_ONE) ||
                          (previous_buttons == gpm_pkg::COMBO_TWO);

  always_comb begin
    capture_word_next     = capture_word;
    bit_index_next        = bit_index;
    running_next          = running;
    idle_counter_next     = idle_counter;
    light_state_next      = light_state;
    model_wide_next       = model_wide;
    previous_buttons_next = previous_buttons;
    shown_buttons_next    = shown_buttons;
    region_flag_next      = region_flag;
    frame_done            = 1'b0;
    poll_taken            = 1'b0;
    model_changed         = 1'b0;

    unique case (in_data.command)
      gpm_pkg::CMD_LATCH_FALL: begin
        running_next      = 1'b1;
        capture_word_next = '0;
      end
      gpm_pkg::CMD_CLOCK_FALL: begin
        // active-low data, indexes past the word set nothing
        if (running && !in_data.data_line && bit_index < gpm_pkg::CAPTURE_BITS) begin
          capture_word_next = capture_word | (16'd1 << bit_index[3:0]);
        end
      end
      gpm_pkg::CMD_CLOCK_RISE: begin
        if (running) begin
          bit_index_next = index_inc;
          if (index_inc >= frame_limit) begin
            running_next   = 1'b0;
            bit_index_next = '0;
            frame_done     = 1'b1;
            if (idle_counter < idle_off_frames && held == '0) begin
              idle_counter_next = idle_counter + 16'd1;
            end else if (held != '0) begin
              idle_counter_next = '0;
            end
          end
        end
      end
      gpm_pkg::CMD_POLL: begin
        if (!running) begin
          poll_taken         = 1'b1;
          region_flag_next   = in_data.clock_line_pulled;
          shown_buttons_next = held;
          if (light_state == gpm_pkg::LIGHT_FULL) begin
            if (idle_counter >= idle_dim_frames) begin
              light_state_next = gpm_pkg::LIGHT_DIM;
            end
          end else if (light_state == gpm_pkg::LIGHT_DIM && idle_counter == idle_off_frames) begin
            light_state_next = gpm_pkg::LIGHT_OFF;
          end else if (idle_counter < idle_dim_frames) begin
            light_state_next = gpm_pkg::LIGHT_FULL;
          end
          // model check is skipped while the light is off
          if (light_state_next != gpm_pkg::LIGHT_OFF) begin
            if (saved_combo && !previous_combo) begin
              model_wide_next = !model_wide;
              model_changed   = 1'b1;
            end
            previous_buttons_next = held;
          end
        end
      end
      default: ;
    endcase

    case (light_state_next)
      gpm_pkg::LIGHT_FULL: level = gpm_pkg::LEVEL_FULL;
      gpm_pkg::LIGHT_DIM:  level = dim_level;
      default:             level = gpm_pkg::LEVEL_OFF;
    endcase

    result.button_bits     = shown_buttons_next;
    result.frame_done      = frame_done;
    result.idle_frames     = idle_counter_next;
    result.backlight_level = level;
    result.display_on      = light_state_next != gpm_pkg::LIGHT_OFF;
    result.wide_model      = model_wide_next;
    result.pal_region      = region_flag_next;
    result.poll_taken      = poll_taken;
    result.model_changed   = model_changed;
    result.clocking_res    = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_word     <= '0;
      bit_index        <= '0;
      running          <= 1'b0;
      idle_counter     <= '0;
      light_state      <= gpm_pkg::LIGHT_FULL;
      model_wide       <= 1'b1;
      previous_buttons <= '0;
      shown_buttons    <= '0;
      region_flag      <= 1'b0;
    end else if (accept) begin
      capture_word     <= capture_word_next;
      bit_index        <= bit_index_next;
      running          <= running_next;
      idle_counter     <= idle_counter_next;
      light_state      <= light_state_next;
      model_wide       <= model_wide_next;
      previous_buttons <= previous_buttons_next;
      shown_buttons    <= shown_buttons_next;
      region_flag      <= region_flag_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (accept && out_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      if (skid_valid) begin
        out_valid <= 1'b1;
      end else if (accept) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

endmodule
